FILE: design/rps_pkg.sv
// shared types and constants for the ring permutation shuffler
// no dependencies
package rps_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned CMD_W             = 2;
  localparam int unsigned RND_W             = 32;
  localparam int unsigned RIDX_W            = 12;
  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned STRIDE_W          = 21;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 21'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_SHUFFLE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } rps_cmd_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_EXEC
  } rps_state_t;

endpackage

FILE: design/rps_ram.sv
// generic two-port ram, each port reads and writes, registered read data
// no dependencies
module rps_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we_a,
  input  logic [$clog2(DEPTH)-1:0] addr_a,
  input  logic [WIDTH-1:0]         wdata_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     we_b,
  input  logic [$clog2(DEPTH)-1:0] addr_b,
  input  logic [WIDTH-1:0]         wdata_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem[addr_a] <= wdata_a;
    end
    if (we_b) begin
      mem[addr_b] <= wdata_b;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

endmodule

FILE: design/rps_mod.sv
// pipelined reduction of a 32-bit word modulo the table size
// reciprocal multiply, back multiply, two correction steps; no dependencies
module rps_mod #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [31:0]                      value,
  output logic                             done,
  output logic [$clog2(TABLE_ENTRIES)-1:0] result
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / TABLE_ENTRIES;
  localparam logic [31:0] RECIP = RECIP64[31:0];
  localparam logic [31:0] N32 = 32'(TABLE_ENTRIES);

  logic        v1_r, v2_r, v3_r;
  logic [63:0] prod1_r;
  logic [31:0] val1_r;
  logic [31:0] rem2_r;
  logic [AW-1:0] result_r;

  logic [63:0] prod2;
  logic [31:0] r1, r2;

  always_comb begin
    prod2 = 64'(prod1_r[63:32]) * 64'(N32);
    r1 = (rem2_r >= N32) ? rem2_r - N32 : rem2_r;
    r2 = (r1 >= N32) ? r1 - N32 : r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    prod1_r  <= 64'(value) * 64'(RECIP);
    val1_r   <= value;
    rem2_r   <= val1_r - prod2[31:0];
    result_r <= r2[AW-1:0];
  end

  assign done   = v3_r;
  assign result = result_r;

endmodule

FILE: design/ring_permutation_shuffler_top.sv
// ring permutation shuffler: table in a two-port ram, swap or scaled read per beat
// depends on rps_pkg, rps_ram, rps_mod
// result registered as ST_EXEC fires (held off by a full output); no new beat until then
// a shuffle with a table size that is not a power of two first runs the modulo pipeline
// restart: result, then a ring refill of all TABLE_ENTRIES entries with input held off
// reset: synchronous; ring fill sweep of all TABLE_ENTRIES entries before the first beat
module ring_permutation_shuffler_top #(
  parameter int unsigned TABLE_ENTRIES = rps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rps_pkg::STRIDE_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rps_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rps_pkg::RND_W-1:0]    in_random_word,
  input  logic [rps_pkg::RIDX_W-1:0]   in_read_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rps_pkg::VALUE_W-1:0]  out_entry_value,
  output logic                         out_shuffle_done,
  output logic                         out_status
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW = (AW > rps_pkg::RIDX_W) ? AW : rps_pkg::RIDX_W;
  localparam int unsigned PW = AW + rps_pkg::STRIDE_W;
  localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [SW-1:0] SWAPS_FULL = SW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  rps_pkg::rps_state_t state_r, state_nxt;
  rps_pkg::rps_cmd_t   cmd_r, in_cmd_e;

  logic [rps_pkg::RIDX_W-1:0]   ridx_r;
  logic [AW-1:0]                partner_r, partner_nxt;
  logic [SW-1:0]                swaps_left_r, swaps_left_nxt;
  logic [AW-1:0]                fill_cnt_r, fill_cnt_nxt;
  logic [rps_pkg::STRIDE_W-1:0] stride_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [rps_pkg::VALUE_W-1:0]  out_value_r, value_nxt;
  logic                         out_done_r, done_nxt;
  logic                         out_status_r, status_nxt;

  logic          accept, out_free, exec_fire, swap_ok, ridx_ok;
  logic          mod_start, mod_done;
  logic [AW-1:0] mod_result;
  logic [AW-1:0] pos, ridx_in_addr, ridx_r_addr;
  logic [SW-1:0] pos_wide;
  logic [RW-1:0] ridx_in_w, ridx_r_w;
  logic [PW-1:0] prod;

  logic          we_a, we_b;
  logic [AW-1:0] addr_a, addr_b, wdata_a, wdata_b, rdata_a, rdata_b;

  rps_ram #(
    .WIDTH (AW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we_a    (we_a),
    .addr_a  (addr_a),
    .wdata_a (wdata_a),
    .rdata_a (rdata_a),
    .we_b    (we_b),
    .addr_b  (addr_b),
    .wdata_b (wdata_b),
    .rdata_b (rdata_b)
  );

  rps_mod #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .value  (in_random_word),
    .done   (mod_done),
    .result (mod_result)
  );

  assign in_cmd_e     = rps_pkg::rps_cmd_t'(in_cmd);
  assign pos_wide     = swaps_left_r - SW'(1);
  assign pos          = pos_wide[AW-1:0];
  assign ridx_in_w    = RW'(in_read_index);
  assign ridx_in_addr = ridx_in_w[AW-1:0];
  assign ridx_r_w     = RW'(ridx_r);
  assign ridx_r_addr  = ridx_r_w[AW-1:0];
  assign ridx_ok      = (32'(ridx_r) < 32'(TABLE_ENTRIES));
  assign swap_ok      = (cmd_r == rps_pkg::CMD_SHUFFLE) && (swaps_left_r != '0);
  assign prod         = PW'(rdata_a) * PW'(stride_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rps_pkg::ST_FILL: begin
        if (fill_cnt_r == LAST_IDX) begin
          state_nxt = rps_pkg::ST_IDLE;
        end
      end
      rps_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mod_start ? rps_pkg::ST_REDUCE : rps_pkg::ST_EXEC;
        end
      end
      rps_pkg::ST_REDUCE: begin
        if (mod_done) begin
          state_nxt = rps_pkg::ST_READ;
        end
      end
      rps_pkg::ST_READ: begin
        state_nxt = rps_pkg::ST_EXEC;
      end
      rps_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt = (cmd_r == rps_pkg::CMD_RESTART) ? rps_pkg::ST_FILL : rps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rps_pkg::ST_FILL;
      end
    endcase
  end

  // control and datapath
  always_comb begin
    in_ready  = (state_r == rps_pkg::ST_IDLE);
    accept    = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;
    exec_fire = (state_r == rps_pkg::ST_EXEC) && out_free;
    mod_start = accept && (in_cmd_e == rps_pkg::CMD_SHUFFLE) && (swaps_left_r != '0) &&
                !IS_POW2;

    we_a    = 1'b0;
    we_b    = 1'b0;
    wdata_a = rdata_b;
    wdata_b = rdata_a;
    addr_a  = (cmd_r == rps_pkg::CMD_READ) ? ridx_r_addr : pos;
    addr_b  = partner_r;
    case (state_r)
      rps_pkg::ST_FILL: begin
        addr_a  = fill_cnt_r;
        we_a    = 1'b1;
        wdata_a = (fill_cnt_r == LAST_IDX) ? '0 : fill_cnt_r + AW'(1);
      end
      rps_pkg::ST_IDLE: begin
        addr_a = (in_cmd_e == rps_pkg::CMD_READ) ? ridx_in_addr : pos;
        addr_b = in_random_word[AW-1:0];
      end
      rps_pkg::ST_EXEC: begin
        we_a = exec_fire && swap_ok;
        we_b = exec_fire && swap_ok;
      end
      default: begin
        we_a = 1'b0;
      end
    endcase

    partner_nxt = partner_r;
    if (accept) begin
      partner_nxt = in_random_word[AW-1:0];
    end else if ((state_r == rps_pkg::ST_REDUCE) && mod_done) begin
      partner_nxt = mod_result;
    end

    fill_cnt_nxt = fill_cnt_r;
    if (state_r == rps_pkg::ST_FILL) begin
      fill_cnt_nxt = (fill_cnt_r == LAST_IDX) ? '0 : fill_cnt_r + AW'(1);
    end

    swaps_left_nxt = swaps_left_r;
    value_nxt      = '0;
    status_nxt     = 1'b0;
    case (cmd_r)
      rps_pkg::CMD_RESTART: begin
        swaps_left_nxt = SWAPS_FULL;
      end
      rps_pkg::CMD_SHUFFLE: begin
        if (swap_ok) begin
          swaps_left_nxt = pos_wide;
        end else begin
          status_nxt = 1'b1;
        end
      end
      rps_pkg::CMD_READ: begin
        if (ridx_ok) begin
          value_nxt = 32'(prod);
        end
      end
      default: begin
        value_nxt = '0;
      end
    endcase
    done_nxt = (swaps_left_nxt == '0);

    out_valid_nxt = out_valid_r && !out_ready;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rps_pkg::ST_FILL;
      fill_cnt_r   <= '0;
      swaps_left_r <= SWAPS_FULL;
      stride_r     <= rps_pkg::STRIDE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        swaps_left_r <= swaps_left_nxt;
      end
      if (cfg_wr_en) begin
        stride_r <= cfg_wr_data;
      end
    end
    partner_r <= partner_nxt;
    if (accept) begin
      cmd_r  <= in_cmd_e;
      ridx_r <= in_read_index;
    end
    if (exec_fire) begin
      out_value_r  <= value_nxt;
      out_done_r   <= done_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_value  = out_value_r;
  assign out_shuffle_done = out_done_r;
  assign out_status       = out_status_r;

endmodule
